/* sv/rsmt_pkg.sv */
// Shared types, codes and helpers of the range subtract minimum tree.
`timescale 1ns / 1ps

package rsmt_pkg;

   localparam int VALUE_W = 32;
   localparam int TOTAL_W = 64;
   localparam int WORD_W  = 2 * VALUE_W;
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_MIN    = 2'd1;
   localparam logic [OP_W-1:0] OP_SUB    = 2'd2;
   localparam logic [OP_W-1:0] OP_GREEDY = 2'd3;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VISIT,
      ST_COVER_WAIT,
      ST_NODE_WAIT,
      ST_CHILD_A_WAIT,
      ST_CHILD_B_WAIT,
      ST_PUSH_CLEAR,
      ST_SPLIT,
      ST_REF_A_WAIT,
      ST_REF_B_WAIT,
      ST_PASS_END,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADJUST,
      ALU_LOAD,
      ALU_KEEP,
      ALU_SMIN
   } alu_op_type;

   typedef struct packed {
      logic       pop;
      logic [1:0] push_count;
   } stk_ctrl_type;

   typedef struct packed {
      logic empty;
      logic last;
   } stk_stat_type;

   function automatic logic [VALUE_W-1:0] smin(input logic [VALUE_W-1:0] a,
                                               input logic [VALUE_W-1:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

endpackage

/* sv/rsmt_node_ram.sv */
// Node memory: one write port and one registered read port.
`timescale 1ns / 1ps

module rsmt_node_ram #(
   parameter int ADDR_W = 12
) (
   input  logic                       clock,
   input  logic                       write_enable,
   input  logic [ADDR_W-1:0]          write_addr,
   input  logic [rsmt_pkg::WORD_W-1:0] write_data,
   input  logic [ADDR_W-1:0]          read_addr,
   output logic [rsmt_pkg::WORD_W-1:0] read_data
);
   import rsmt_pkg::*;

   logic [WORD_W-1:0] mem [(1 << ADDR_W)];
   logic [WORD_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

/* sv/rsmt_node_alu.sv */
// Shared node arithmetic unit: adjust, load, keep and signed minimum.
`timescale 1ns / 1ps

module rsmt_node_alu (
   input  rsmt_pkg::alu_op_type         alu_op,
   input  logic [rsmt_pkg::WORD_W-1:0]  node_word,
   input  logic [rsmt_pkg::VALUE_W-1:0] operand,
   input  logic [rsmt_pkg::VALUE_W-1:0] side_value,
   output logic [rsmt_pkg::WORD_W-1:0]  result_word
);
   import rsmt_pkg::*;

   logic [VALUE_W-1:0] node_min;
   logic [VALUE_W-1:0] node_pend;

   always_comb begin
      node_min  = node_word[WORD_W-1 -: VALUE_W];
      node_pend = node_word[VALUE_W-1:0];
      unique case (alu_op)
         ALU_ADJUST: result_word = {node_min - operand, node_pend + operand};
         ALU_LOAD:   result_word = {operand, {VALUE_W{1'b0}}};
         ALU_KEEP:   result_word = {side_value, {VALUE_W{1'b0}}};
         ALU_SMIN:   result_word = {smin(side_value, node_min), {VALUE_W{1'b0}}};
      endcase
   end

endmodule

/* sv/rsmt_frame_stack.sv */
// Traversal stack of pending tree frames, read at the top only.
`timescale 1ns / 1ps

module rsmt_frame_stack #(
   parameter int FRAME_W = 33,
   parameter int DEPTH   = 26
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsmt_pkg::stk_ctrl_type stk_ctrl,
   input  logic [FRAME_W-1:0]    push_frame0,
   input  logic [FRAME_W-1:0]    push_frame1,
   output logic [FRAME_W-1:0]    top_frame,
   output rsmt_pkg::stk_stat_type stk_stat
);
   import rsmt_pkg::*;

   localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SPW = $clog2(DEPTH + 1);

   logic [FRAME_W-1:0] entry_ff [DEPTH];
   logic [SPW-1:0]     sp_ff;
   logic [SPW-1:0]     sp_in;
   logic [SPW-1:0]     base;
   logic [SPW-1:0]     base_next;
   logic [SPW-1:0]     top_ptr;

   always_comb begin
      base      = sp_ff - SPW'(stk_ctrl.pop);
      base_next = base + SPW'(1);
      sp_in     = base + SPW'(stk_ctrl.push_count);
      top_ptr   = sp_ff - SPW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_ctrl.push_count != 2'd0) begin
         entry_ff[base[IW-1:0]] <= push_frame0;
      end
      if (stk_ctrl.push_count == 2'd2) begin
         entry_ff[base_next[IW-1:0]] <= push_frame1;
      end
   end

   assign top_frame      = entry_ff[top_ptr[IW-1:0]];
   assign stk_stat.empty = (sp_ff == '0);
   assign stk_stat.last  = (sp_ff == SPW'(1));

endmodule

/* sv/range_subtract_min_tree.sv */
// Operation: an empty item goes straight to the result; otherwise a query pass reads each covered
// node and descends through each split node (plus a push when pending), and an update pass
// pushes, descends and refreshes each split node, all through the single node memory port.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous; afterwards a clearing pass writes zero to all 4*2^clog2(MAX_ELEMENTS)
// node words before the first item is accepted.
`timescale 1ns / 1ps

module range_subtract_min_tree #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [rsmt_pkg::COUNT_W-1:0]       csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rsmt_pkg::OP_W-1:0]          req_operation,
   input  logic [rsmt_pkg::INDEX_W-1:0]       req_index_low,
   input  logic [rsmt_pkg::INDEX_W-1:0]       req_index_high,
   input  logic signed [rsmt_pkg::VALUE_W-1:0] req_amount,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [rsmt_pkg::VALUE_W-1:0] rsp_range_minimum,
   output logic                               rsp_empty_range,
   output logic signed [rsmt_pkg::TOTAL_W-1:0] rsp_running_total
);
   import rsmt_pkg::*;

   localparam int EW = $clog2(MAX_ELEMENTS);
   localparam int NW = EW + 2;
   localparam int FW = 1 + NW + 2 * EW;
   localparam int SD = 2 * NW + 2;
   localparam int CW = (EW + 1 > COUNT_W) ? EW + 1 : COUNT_W;

   state_type          state_ff, state_in;
   logic [NW-1:0]      clr_ff, clr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [OP_W-1:0]    op_ff, op_in;
   logic               pass_sub_ff, pass_sub_in;
   logic               empty_ff, empty_in;
   logic [EW-1:0]      bound_lo_ff, bound_lo_in;
   logic [EW-1:0]      bound_hi_ff, bound_hi_in;
   logic [VALUE_W-1:0] amount_ff, amount_in;
   logic [VALUE_W-1:0] delta_ff, delta_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [VALUE_W-1:0] pend_ff, pend_in;
   logic [VALUE_W-1:0] min_t_ff, min_t_in;
   logic [VALUE_W-1:0] min_a_ff, min_a_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_min_ff, rsp_min_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   stk_ctrl_type       stk_ctrl;
   stk_stat_type       stk_stat;
   logic [FW-1:0]      push_frame0, push_frame1, top_frame;

   logic               ram_we;
   logic [NW-1:0]      ram_waddr, ram_raddr;
   logic [WORD_W-1:0]  ram_wdata, ram_rdata, alu_result;
   alu_op_type         alu_op;
   logic [VALUE_W-1:0] alu_operand, alu_side;

   logic               top_stage;
   logic [NW-1:0]      top_node, child_a, child_b;
   logic [EW-1:0]      top_lo, top_hi, mid;
   logic [EW:0]        mid_sum;
   logic               covered, go_left, go_right;
   logic [FW-1:0]      left_frame, right_frame, root_frame, marker_frame;
   logic [CW-1:0]      count_cap, lo_ext, hi_ext, hi_clamp;
   logic               req_empty;
   logic               accept;
   logic [VALUE_W-1:0] rd_min, rd_pend;

   rsmt_node_ram #(.ADDR_W(NW)) u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   rsmt_node_alu u_alu (
      .alu_op      (alu_op),
      .node_word   (ram_rdata),
      .operand     (alu_operand),
      .side_value  (alu_side),
      .result_word (alu_result)
   );

   rsmt_frame_stack #(.FRAME_W(FW), .DEPTH(SD)) u_stack (
      .clock       (clock),
      .reset       (reset),
      .stk_ctrl    (stk_ctrl),
      .push_frame0 (push_frame0),
      .push_frame1 (push_frame1),
      .top_frame   (top_frame),
      .stk_stat    (stk_stat)
   );

   // Frame decode and child ranges of the node on top of the stack.
   always_comb begin
      top_stage    = top_frame[FW-1];
      top_node     = top_frame[FW-2 -: NW];
      top_lo       = top_frame[2*EW-1 -: EW];
      top_hi       = top_frame[EW-1:0];
      child_a      = {top_node[NW-2:0], 1'b0};
      child_b      = {top_node[NW-2:0], 1'b1};
      mid_sum      = {1'b0, top_lo} + {1'b0, top_hi};
      mid          = mid_sum[EW:1];
      covered      = (top_lo >= bound_lo_ff) && (top_hi <= bound_hi_ff);
      go_left      = (bound_lo_ff <= mid);
      go_right     = (bound_hi_ff > mid);
      left_frame   = {1'b0, child_a, top_lo, mid};
      right_frame  = {1'b0, child_b, mid + EW'(1), top_hi};
      marker_frame = {1'b1, top_frame[FW-2:0]};
      root_frame   = {1'b0, NW'(1), EW'(0), EW'(MAX_ELEMENTS - 1)};
      rd_min       = ram_rdata[WORD_W-1 -: VALUE_W];
      rd_pend      = ram_rdata[VALUE_W-1:0];
   end

   // Range checks of the incoming item.
   always_comb begin
      count_cap = (CW'(count_ff) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(count_ff);
      lo_ext    = CW'(req_index_low);
      hi_ext    = CW'(req_index_high);
      hi_clamp  = ((count_cap != '0) && (hi_ext >= count_cap)) ? count_cap - CW'(1) : hi_ext;
      if (req_operation == OP_LOAD) begin
         req_empty = (lo_ext >= count_cap);
      end else begin
         req_empty = (lo_ext >= count_cap) || (lo_ext > hi_clamp);
      end
      accept = req_valid && !req_stall;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      pass_sub_in  = pass_sub_ff;
      empty_in     = empty_ff;
      bound_lo_in  = bound_lo_ff;
      bound_hi_in  = bound_hi_ff;
      amount_in    = amount_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      min_t_in     = min_t_ff;
      min_a_in     = min_a_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_min_in   = rsp_min_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_total_in = rsp_total_ff;
      stk_ctrl     = '{pop: 1'b0, push_count: 2'd0};
      push_frame0  = root_frame;
      push_frame1  = left_frame;
      ram_we       = 1'b0;
      ram_waddr    = top_node;
      ram_raddr    = top_node;
      ram_wdata    = alu_result;
      alu_op       = ALU_ADJUST;
      alu_operand  = delta_ff;
      alu_side     = acc_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + NW'(1);
            if (clr_ff == {NW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               amount_in   = req_amount;
               empty_in    = req_empty;
               pass_sub_in = (req_operation == OP_LOAD);
               acc_in      = VALUE_MAX;
               bound_lo_in = lo_ext[EW-1:0];
               bound_hi_in = (req_operation == OP_LOAD) ? lo_ext[EW-1:0] : hi_clamp[EW-1:0];
               if (req_empty) begin
                  state_in = ST_DONE;
               end else begin
                  stk_ctrl = '{pop: 1'b0, push_count: 2'd1};
                  state_in = ST_VISIT;
               end
            end
         end
         ST_VISIT: begin
            priority if (top_stage) begin
               ram_raddr = child_a;
               state_in  = ST_REF_A_WAIT;
            end else if (covered) begin
               state_in = ST_COVER_WAIT;
            end else begin
               // An update leaves a marker so that the node is refreshed after its children.
               if (pass_sub_ff) begin
                  stk_ctrl    = '{pop: 1'b1, push_count: 2'd1};
                  push_frame0 = marker_frame;
               end
               state_in = ST_NODE_WAIT;
            end
         end
         ST_COVER_WAIT: begin
            if (!pass_sub_ff) begin
               alu_op = ALU_SMIN;
               acc_in = alu_result[WORD_W-1 -: VALUE_W];
            end else begin
               ram_we      = 1'b1;
               alu_op      = (op_ff == OP_LOAD) ? ALU_LOAD : ALU_ADJUST;
               alu_operand = (op_ff == OP_LOAD) ? amount_ff : delta_ff;
            end
            stk_ctrl.pop = 1'b1;
            state_in     = stk_stat.last ? ST_PASS_END : ST_VISIT;
         end
         ST_NODE_WAIT: begin
            min_t_in = rd_min;
            pend_in  = rd_pend;
            if (rd_pend == '0) begin
               state_in = ST_SPLIT;
            end else begin
               ram_raddr = child_a;
               state_in  = ST_CHILD_A_WAIT;
            end
         end
         ST_CHILD_A_WAIT: begin
            ram_we      = 1'b1;
            ram_waddr   = child_a;
            alu_operand = pend_ff;
            ram_raddr   = child_b;
            state_in    = ST_CHILD_B_WAIT;
         end
         ST_CHILD_B_WAIT: begin
            ram_we      = 1'b1;
            ram_waddr   = child_b;
            alu_operand = pend_ff;
            state_in    = ST_PUSH_CLEAR;
         end
         ST_PUSH_CLEAR: begin
            ram_we   = 1'b1;
            alu_op   = ALU_KEEP;
            alu_side = min_t_ff;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            // A query has no refresh to come, so its frame is replaced by the children.
            stk_ctrl.pop = !pass_sub_ff;
            if (go_left && go_right) begin
               stk_ctrl.push_count = 2'd2;
               push_frame0         = right_frame;
               push_frame1         = left_frame;
            end else begin
               stk_ctrl.push_count = 2'd1;
               push_frame0         = go_left ? left_frame : right_frame;
            end
            state_in = ST_VISIT;
         end
         ST_REF_A_WAIT: begin
            min_a_in  = rd_min;
            ram_raddr = child_b;
            state_in  = ST_REF_B_WAIT;
         end
         ST_REF_B_WAIT: begin
            ram_we       = 1'b1;
            alu_op       = ALU_SMIN;
            alu_side     = min_a_ff;
            stk_ctrl.pop = 1'b1;
            state_in     = stk_stat.last ? ST_PASS_END : ST_VISIT;
         end
         ST_PASS_END: begin
            if (!pass_sub_ff && (op_ff != OP_MIN)) begin
               pass_sub_in = 1'b1;
               delta_in    = (op_ff == OP_GREEDY) ? acc_ff : amount_ff;
               if (op_ff == OP_GREEDY) begin
                  total_in = total_ff + {{(TOTAL_W - VALUE_W){acc_ff[VALUE_W-1]}}, acc_ff};
               end
               stk_ctrl = '{pop: 1'b0, push_count: 2'd1};
               state_in = ST_VISIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = (empty_ff || (op_ff == OP_LOAD)) ? '0 : acc_ff;
               rsp_empty_in = empty_ff;
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= COUNT_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pass_sub_ff  <= 1'b0;
         op_ff        <= OP_LOAD;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_sub_ff  <= pass_sub_in;
         op_ff        <= op_in;
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      empty_ff     <= empty_in;
      bound_lo_ff  <= bound_lo_in;
      bound_hi_ff  <= bound_hi_in;
      amount_ff    <= amount_in;
      delta_ff     <= delta_in;
      acc_ff       <= acc_in;
      pend_ff      <= pend_in;
      min_t_ff     <= min_t_in;
      min_a_ff     <= min_a_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_minimum = rsp_min_ff;
   assign rsp_empty_range   = rsp_empty_ff;
   assign rsp_running_total = rsp_total_ff;

   // An item is taken only when no traversal is left on the stack.
   a_idle_stack_empty: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> stk_stat.empty)
      else $error("item accepted while frames remain on the stack");

   a_visit_has_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VISIT) |-> !stk_stat.empty)
      else $error("node visit with an empty stack");

   a_pass_end_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS_END) |-> stk_stat.empty)
      else $error("pass ended with frames left");

   a_empty_zero_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_range) |-> (rsp_range_minimum == '0))
      else $error("empty range reported a nonzero minimum");

   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid)
      else $error("result present during the clearing pass");

endmodule

/* test/tb.sv */
// Self-checking testbench of the range subtract minimum tree.
`timescale 1ns / 1ps

module tb;
   import rsmt_pkg::*;

   localparam int LEAVES = 1024;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] lo;
      logic [INDEX_W-1:0] hi;
      logic [VALUE_W-1:0] amount;
   } tree_op_type;

   typedef struct {
      logic [VALUE_W-1:0] minimum;
      logic               empty;
      logic [TOTAL_W-1:0] total;
   } tree_result_type;

   typedef struct {
      tree_op_type     op;
      logic            known;
      tree_result_type result;
   } table_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [COUNT_W-1:0] csr_write_data;
   logic req_valid;
   logic req_stall;
   logic [OP_W-1:0] req_operation;
   logic [INDEX_W-1:0] req_index_low;
   logic [INDEX_W-1:0] req_index_high;
   logic signed [VALUE_W-1:0] req_amount;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [VALUE_W-1:0] rsp_range_minimum;
   logic rsp_empty_range;
   logic signed [TOTAL_W-1:0] rsp_running_total;

   range_subtract_min_tree #(.MAX_ELEMENTS(LEAVES)) uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_index_low(req_index_low),
      .req_index_high(req_index_high), .req_amount(req_amount),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_range_minimum(rsp_range_minimum), .rsp_empty_range(rsp_empty_range),
      .rsp_running_total(rsp_running_total)
   );

   // Predictor state.
   logic [VALUE_W-1:0] tree_min[4*LEAVES];
   logic [VALUE_W-1:0] tree_pend[4*LEAVES];
   logic [TOTAL_W-1:0] greedy_sum;
   logic [COUNT_W-1:0] active_count;

   tree_result_type expected_results[$];
   logic            expected_known[$];
   tree_result_type typed_results[$];
   int errors;
   int idle_cycles;
   bit quiet_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [VALUE_W-1:0] lower_of(logic [VALUE_W-1:0] a,
                                                    logic [VALUE_W-1:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic void push_down(int t);
      logic [VALUE_W-1:0] p;
      p = tree_pend[t];
      if (p != 0) begin
         tree_pend[2*t] += p;
         tree_pend[2*t+1] += p;
         tree_min[2*t] -= p;
         tree_min[2*t+1] -= p;
         tree_pend[t] = '0;
      end
   endfunction

   function automatic void write_leaf(int lo, int hi, int t, int pos, logic [VALUE_W-1:0] v);
      int mid;
      if (lo == hi) begin
         tree_min[t] = v;
         tree_pend[t] = '0;
         return;
      end
      push_down(t);
      mid = (lo + hi) >> 1;
      if (pos <= mid) write_leaf(lo, mid, 2*t, pos, v);
      else write_leaf(mid + 1, hi, 2*t+1, pos, v);
      tree_min[t] = lower_of(tree_min[2*t], tree_min[2*t+1]);
   endfunction

   function automatic void lower_range(int lo, int hi, int t, int l, int r,
                                       logic [VALUE_W-1:0] d);
      int mid;
      if (lo >= l && hi <= r) begin
         tree_min[t] -= d;
         tree_pend[t] += d;
         return;
      end
      push_down(t);
      mid = (lo + hi) >> 1;
      if (l <= mid) lower_range(lo, mid, 2*t, l, r, d);
      if (r > mid) lower_range(mid + 1, hi, 2*t+1, l, r, d);
      tree_min[t] = lower_of(tree_min[2*t], tree_min[2*t+1]);
   endfunction

   function automatic logic [VALUE_W-1:0] range_low(int lo, int hi, int t, int l, int r);
      int mid;
      if (lo >= l && hi <= r) return tree_min[t];
      push_down(t);
      mid = (lo + hi) >> 1;
      if (r <= mid) return range_low(lo, mid, 2*t, l, r);
      if (l > mid) return range_low(mid + 1, hi, 2*t+1, l, r);
      return lower_of(range_low(lo, mid, 2*t, l, r), range_low(mid + 1, hi, 2*t+1, l, r));
   endfunction

   function automatic tree_result_type apply_tree_op(tree_op_type item);
      tree_result_type res;
      int count;
      int hi;
      count = (active_count > LEAVES) ? LEAVES : int'(active_count);
      hi = item.hi;
      res.minimum = '0;
      res.empty = 1'b0;
      if (item.op == OP_LOAD) begin
         if (item.lo >= count) res.empty = 1'b1;
         else write_leaf(0, LEAVES - 1, 1, item.lo, item.amount);
      end else begin
         if (count != 0 && hi >= count) hi = count - 1;
         if (item.lo >= count || item.lo > hi) begin
            res.empty = 1'b1;
         end else begin
            res.minimum = range_low(0, LEAVES - 1, 1, item.lo, hi);
            if (item.op == OP_SUB) begin
               lower_range(0, LEAVES - 1, 1, item.lo, hi, item.amount);
            end else if (item.op == OP_GREEDY) begin
               greedy_sum += {{32{res.minimum[31]}}, res.minimum};
               lower_range(0, LEAVES - 1, 1, item.lo, hi, res.minimum);
            end
         end
      end
      res.total = greedy_sum;
      return res;
   endfunction

   function automatic bit idle_now();
      return !quiet_mode && ($urandom_range(99) < 36);
   endfunction

   // Result side: random stall and checking.
   always @(posedge clock) begin
      tree_result_type want;
      logic typed;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with none expected: min %0d empty %0b total %0d",
                        $time, rsp_range_minimum, rsp_empty_range, rsp_running_total);
               errors++;
            end else begin
               want = expected_results.pop_front();
               typed = expected_known.pop_front();
               if (typed) begin
                  // Directed rows with a typed-in answer must also match the predictor.
                  if (typed_results.pop_front() != want) begin
                     $display("%0t: table row disagrees with prediction", $time);
                     errors++;
                  end
               end
               if (rsp_range_minimum !== want.minimum) begin
                  $display("%0t: range_minimum expected %0d actual %0d", $time,
                           $signed(want.minimum), rsp_range_minimum);
                  errors++;
               end
               if (rsp_empty_range !== want.empty) begin
                  $display("%0t: empty_range expected %0b actual %0b", $time,
                           want.empty, rsp_empty_range);
                  errors++;
               end
               if (rsp_running_total !== want.total) begin
                  $display("%0t: running_total expected %0d actual %0d", $time,
                           $signed(want.total), rsp_running_total);
                  errors++;
               end
            end
         end
         rsp_stall <= idle_now();
      end
   end

   // Watchdog on cycles with nothing accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Valid stays high after an item is taken until the next idle cycle or item, so that
   // it gets at most one update in a time step; the block is busy right after an item.
   task automatic send_item(tree_op_type item, logic known, tree_result_type typed_res);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= item.op;
      req_index_low <= item.lo;
      req_index_high <= item.hi;
      req_amount <= item.amount;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Accepted at this edge.
      expected_results.push_back(apply_tree_op(item));
      expected_known.push_back(known);
      if (known) typed_results.push_back(typed_res);
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count = value;
   endtask

   function automatic tree_op_type random_op(int span);
      tree_op_type item;
      int a;
      int b;
      item.op = OP_W'($urandom_range(3));
      a = $urandom_range(span - 1);
      b = a + $urandom_range(span - 1 - a);
      if ($urandom_range(19) == 0) begin
         item.lo = INDEX_W'($urandom);
         item.hi = INDEX_W'($urandom);
      end else begin
         item.lo = INDEX_W'(a);
         item.hi = INDEX_W'(b);
      end
      case ($urandom_range(3))
         0: item.amount = $urandom;
         1: item.amount = VALUE_W'($urandom_range(200)) - 100;
         default: item.amount = item.op == OP_LOAD ? $urandom_range(1000) : $urandom_range(9);
      endcase
      return item;
   endfunction

   table_row_type directed[$];
   tree_result_type none;

   function automatic table_row_type row(logic [OP_W-1:0] op, int lo, int hi,
                                         logic [VALUE_W-1:0] amt, logic known,
                                         logic [VALUE_W-1:0] mn, logic em,
                                         logic [TOTAL_W-1:0] tot);
      table_row_type r;
      r.op.op = op;
      r.op.lo = INDEX_W'(lo);
      r.op.hi = INDEX_W'(hi);
      r.op.amount = amt;
      r.known = known;
      r.result.minimum = mn;
      r.result.empty = em;
      r.result.total = tot;
      return r;
   endfunction

   initial begin
      tree_op_type item;
      int span;
      foreach (tree_min[i]) begin
         tree_min[i] = '0;
         tree_pend[i] = '0;
      end
      greedy_sum = '0;
      active_count = COUNT_RESET;
      errors = 0;
      quiet_mode = 1'b0;
      none = '{default: '0};
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_operation = OP_LOAD;
      req_index_low = '0;
      req_index_high = '0;
      req_amount = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table; answers typed in where obvious.
      directed.push_back(row(OP_MIN, 0, 1023, 0, 1, 0, 0, 0));
      directed.push_back(row(OP_MIN, 5, 4, 0, 1, 0, 1, 0));
      directed.push_back(row(OP_LOAD, 0, 0, 32'h7fffffff, 1, 0, 0, 0));
      directed.push_back(row(OP_LOAD, 1023, 0, 32'h80000000, 1, 0, 0, 0));
      directed.push_back(row(OP_MIN, 1023, 1023, 0, 1, 32'h80000000, 0, 0));
      directed.push_back(row(OP_MIN, 0, 0, 0, 1, 32'h7fffffff, 0, 0));
      directed.push_back(row(OP_SUB, 0, 1023, 1, 1, 32'h80000000, 0, 0));
      directed.push_back(row(OP_MIN, 1023, 1023, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_MIN, 0, 1023, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_SUB, 0, 511, 32'hffffffff, 0, 0, 0, 0));
      directed.push_back(row(OP_LOAD, 300, 0, 50, 0, 0, 0, 0));
      directed.push_back(row(OP_GREEDY, 300, 300, 0, 1, 50, 0, 50));
      directed.push_back(row(OP_MIN, 300, 300, 0, 1, 0, 0, 50));
      directed.push_back(row(OP_GREEDY, 1000, 1023, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_GREEDY, 3, 700, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_SUB, 10, 10, 32'h80000000, 0, 0, 0, 0));
      directed.push_back(row(OP_MIN, 1023, 0, 0, 0, 0, 1, 0));
      foreach (directed[i])
         send_item(directed[i].op, directed[i].known, directed[i].result);

      // Small count: beyond-count loads, clamped ends, empty ranges.
      write_count(11'd1);
      send_item('{OP_LOAD, 10'd1, 10'd0, 32'd5}, 1'b0, none);
      send_item('{OP_MIN, 10'd0, 10'd1023, 32'd0}, 1'b0, none);
      send_item('{OP_GREEDY, 10'd1, 10'd1, 32'd0}, 1'b0, none);
      write_count(11'd0);
      send_item('{OP_LOAD, 10'd0, 10'd0, 32'd5}, 1'b0, none);
      send_item('{OP_MIN, 10'd0, 10'd0, 32'd0}, 1'b0, none);
      write_count(11'd2047);
      send_item('{OP_MIN, 10'd1023, 10'd1023, 32'd0}, 1'b0, none);

      // Random phases at several counts; the middle phase runs without idling.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: span = 16;
            1: span = 100;
            2: span = 1024;
            3: span = 7;
            default: span = 1024;
         endcase
         write_count(COUNT_W'(phase == 2 ? 1024 : span));
         quiet_mode = (phase == 2);
         for (int n = 0; n < 110; n++) begin
            item = random_op(span + (span < 1024 ? 2 : 0) > 1024 ? 1024
                             : span + (span < 1024 ? 2 : 0));
            send_item(item, 1'b0, none);
         end
      end
      quiet_mode = 1'b0;
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
